FILE: hdl/cau_pkg.sv
package cau_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

endpackage

FILE: hdl/complex_arith_unit.sv
// Complex arithmetic unit: each transaction on the slave stream carries two complex operands
// a and b (real and imaginary parts, signed fixed point with FRAC_BITS fraction bits) and a
// command in tuser (add, subtract, multiply, divide a by b). Every transaction yields exactly
// one result transaction on the master stream, in order: the complex result saturated to
// DATA_WIDTH bits, an overflow flag if either part was clamped, and a divide-by-zero flag
// (result zero) when dividing by b = 0. Multiply truncates toward zero after dropping the
// fraction bits; divide returns the quotient truncated toward zero. The pipeline accepts one
// transaction per cycle; the restoring divider retires one quotient bit per stage. When the
// master side stalls, the whole pipeline holds.
module complex_arith_unit #(
  parameter int unsigned FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // command
  input  logic [1:0]                               s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // r_real, r_imag
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // overflow, div_zero
  output logic [1:0]                               m_axis_tuser
);
  import cau_pkg::*;

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned FB     = FRAC_BITS;
  localparam int unsigned PW     = 2 * DW;          // product width
  localparam int unsigned SW     = PW + 1;          // sum of two products
  localparam int unsigned QW     = DW + 1;          // quotient bits kept
  localparam int unsigned CW     = 3 * DW + FB + 2; // divider remainder width
  localparam int unsigned NDIV   = QW;              // one quotient bit per stage
  localparam int unsigned OUT_TW = ((2 * DW + 7) / 8) * 8;

  localparam logic [QW-1:0] LIM_POS = {2'b00, {(DW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(DW-1){1'b0}}};

  typedef struct packed {
    cmd_e          cmd;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          sat_re;
    logic          sat_im;
    logic [DW-1:0] fix_re;
    logic [DW-1:0] fix_im;
    logic          fix_ovf;
    logic [PW-1:0] den;
  } div_ctl_t;

  function automatic logic [DW-1:0] apply_sign(input logic neg, input logic [QW-1:0] m);
    logic [QW-1:0] t;
    t = neg ? (~m + 1'b1) : m;
    return t[DW-1:0];
  endfunction

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: products and add/subtract
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] ar, ai, br, bi;
  cmd_e                 cmd_in;
  logic signed [DW:0]   as_re_d, as_im_d;

  assign ar     = s_axis_tdata[DW-1:0];
  assign ai     = s_axis_tdata[2*DW-1:DW];
  assign br     = s_axis_tdata[3*DW-1:2*DW];
  assign bi     = s_axis_tdata[4*DW-1:3*DW];
  assign cmd_in = cmd_e'(s_axis_tuser);

  always_comb begin
    if (cmd_in == CMD_SUB) begin
      as_re_d = ar - br;
      as_im_d = ai - bi;
    end else begin
      as_re_d = ar + br;
      as_im_d = ai + bi;
    end
  end

  logic                 v1_q;
  cmd_e                 cmd1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;
  logic signed [DW:0]   as_re1_q, as_im1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q   <= cmd_in;
      p_rr_q   <= ar * br;
      p_ii_q   <= ai * bi;
      p_ri_q   <= ar * bi;
      p_ir_q   <= ai * br;
      sq_r_q   <= br * br;
      sq_i_q   <= bi * bi;
      as_re1_q <= as_re_d;
      as_im1_q <= as_im_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sums of products and squared divisor magnitude
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] sum_re_d, sum_im_d;

  always_comb begin
    if (cmd1_q == CMD_DIV) begin
      sum_re_d = p_rr_q + p_ii_q;
      sum_im_d = p_ir_q - p_ri_q;
    end else begin
      sum_re_d = p_rr_q - p_ii_q;
      sum_im_d = p_ri_q + p_ir_q;
    end
  end

  logic                 v2_q;
  cmd_e                 cmd2_q;
  logic signed [SW-1:0] sum_re_q, sum_im_q;
  logic [PW-1:0]        den2_q;
  logic signed [DW:0]   as_re2_q, as_im2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd2_q   <= cmd1_q;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      den2_q   <= PW'($unsigned(sq_r_q) + $unsigned(sq_i_q));
      as_re2_q <= as_re1_q;
      as_im2_q <= as_im1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sign and magnitude
  // ---------------------------------------------------------------------------
  logic               v3_q;
  cmd_e               cmd3_q;
  logic               neg_re3_q, neg_im3_q;
  logic [PW-1:0]      mag_re3_q, mag_im3_q;
  logic [PW-1:0]      den3_q;
  logic signed [DW:0] as_re3_q, as_im3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd3_q    <= cmd2_q;
      neg_re3_q <= sum_re_q[SW-1];
      neg_im3_q <= sum_im_q[SW-1];
      mag_re3_q <= sum_re_q[SW-1] ? PW'(-sum_re_q) : PW'(sum_re_q);
      mag_im3_q <= sum_im_q[SW-1] ? PW'(-sum_im_q) : PW'(sum_im_q);
      den3_q    <= den2_q;
      as_re3_q  <= as_re2_q;
      as_im3_q  <= as_im2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: finish add/sub/multiply, set up divider
  // ---------------------------------------------------------------------------
  div_ctl_t      ctl0_d;
  logic [CW-1:0] rem_re0_d, rem_im0_d;
  logic [PW-1:0] m_re, m_im, lim_re, lim_im;
  logic          o_re, o_im, a_o_re, a_o_im;
  logic [CW-1:0] dlim;

  always_comb begin
    m_re   = mag_re3_q >> FB;
    m_im   = mag_im3_q >> FB;
    lim_re = PW'(neg_re3_q ? LIM_NEG : LIM_POS);
    lim_im = PW'(neg_im3_q ? LIM_NEG : LIM_POS);
    o_re   = m_re > lim_re;
    o_im   = m_im > lim_im;
    a_o_re = as_re3_q[DW] ^ as_re3_q[DW-1];
    a_o_im = as_im3_q[DW] ^ as_im3_q[DW-1];

    rem_re0_d = CW'(mag_re3_q) << FB;
    rem_im0_d = CW'(mag_im3_q) << FB;
    dlim      = CW'(den3_q) << QW;

    ctl0_d        = '0;
    ctl0_d.cmd    = cmd3_q;
    ctl0_d.den    = den3_q;
    ctl0_d.dz     = (cmd3_q == CMD_DIV) && (den3_q == '0);
    ctl0_d.neg_re = neg_re3_q;
    ctl0_d.neg_im = neg_im3_q;
    ctl0_d.sat_re = rem_re0_d >= dlim;
    ctl0_d.sat_im = rem_im0_d >= dlim;

    if (cmd3_q == CMD_MUL) begin
      ctl0_d.fix_re  = apply_sign(neg_re3_q, o_re ? lim_re[QW-1:0] : m_re[QW-1:0]);
      ctl0_d.fix_im  = apply_sign(neg_im3_q, o_im ? lim_im[QW-1:0] : m_im[QW-1:0]);
      ctl0_d.fix_ovf = o_re || o_im;
    end else begin
      // Clamp the exact add/subtract result to the data range.
      ctl0_d.fix_re  = a_o_re ? {as_re3_q[DW], {(DW-1){!as_re3_q[DW]}}} : as_re3_q[DW-1:0];
      ctl0_d.fix_im  = a_o_im ? {as_im3_q[DW], {(DW-1){!as_im3_q[DW]}}} : as_im3_q[DW-1:0];
      ctl0_d.fix_ovf = a_o_re || a_o_im;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: restoring, one quotient bit per stage, MSB first
  // ---------------------------------------------------------------------------
  logic          vld_q    [NDIV+1];
  div_ctl_t      ctl_q    [NDIV+1];
  logic [CW-1:0] rem_re_q [NDIV+1];
  logic [CW-1:0] rem_im_q [NDIV+1];
  logic [QW-1:0] quo_re_q [NDIV+1];
  logic [QW-1:0] quo_im_q [NDIV+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0]    <= ctl0_d;
      rem_re_q[0] <= rem_re0_d;
      rem_im_q[0] <= rem_im0_d;
      quo_re_q[0] <= '0;
      quo_im_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    localparam int unsigned K = NDIV - 1 - i;
    logic [CW-1:0] dsh;
    logic [CW:0]   tr_re, tr_im;

    assign dsh   = CW'(ctl_q[i].den) << K;
    assign tr_re = {1'b0, rem_re_q[i]} - {1'b0, dsh};
    assign tr_im = {1'b0, rem_im_q[i]} - {1'b0, dsh};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctl_q[i+1]    <= ctl_q[i];
        rem_re_q[i+1] <= tr_re[CW] ? rem_re_q[i] : tr_re[CW-1:0];
        rem_im_q[i+1] <= tr_im[CW] ? rem_im_q[i] : tr_im[CW-1:0];
        quo_re_q[i+1] <= {quo_re_q[i][QW-2:0], !tr_re[CW]};
        quo_im_q[i+1] <= {quo_im_q[i][QW-2:0], !tr_im[CW]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (adv) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: clamp quotient, select result
  // ---------------------------------------------------------------------------
  div_ctl_t      cf;
  logic [QW-1:0] q_re, q_im, dl_re, dl_im;
  logic          d_o_re, d_o_im;
  logic [DW-1:0] r_re_d, r_im_d;
  logic          ovf_d, dz_d;

  always_comb begin
    cf     = ctl_q[NDIV];
    q_re   = quo_re_q[NDIV];
    q_im   = quo_im_q[NDIV];
    dl_re  = cf.neg_re ? LIM_NEG : LIM_POS;
    dl_im  = cf.neg_im ? LIM_NEG : LIM_POS;
    d_o_re = cf.sat_re || (q_re > dl_re);
    d_o_im = cf.sat_im || (q_im > dl_im);
    dz_d   = cf.dz;
    if (cf.cmd != CMD_DIV) begin
      r_re_d = cf.fix_re;
      r_im_d = cf.fix_im;
      ovf_d  = cf.fix_ovf;
    end else if (cf.dz) begin
      r_re_d = '0;
      r_im_d = '0;
      ovf_d  = 1'b0;
    end else begin
      r_re_d = apply_sign(cf.neg_re, d_o_re ? dl_re : q_re);
      r_im_d = apply_sign(cf.neg_im, d_o_im ? dl_im : q_im);
      ovf_d  = d_o_re || d_o_im;
    end
  end

  logic [OUT_TW-1:0] out_data_q;
  logic [1:0]        out_user_q;
  logic              out_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= OUT_TW'({r_im_d, r_re_d});
      out_user_q <= {dz_d, ovf_d};
    end
  end

  // Valid bits travel with the data and hold on a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      vld_q[0]  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      vld_q[0]  <= v3_q;
      out_vld_q <= vld_q[NDIV];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[2*DW-1:0] == '0) && !m_axis_tuser[0])
    else $error("divide by zero must give zero result without overflow");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready must follow output stall");

  a_dz_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && ctl_q[0].dz |-> ctl_q[0].cmd == CMD_DIV)
    else $error("divide-by-zero flag on a non-divide command");

endmodule

FILE: tb/tb_complex_arith_unit.sv
`timescale 1ns / 1ps

module tb_complex_arith_unit;
  import cau_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned DW = DATA_WIDTH_DEF;
  localparam int unsigned LATENCY = DW + 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [DW-1:0] r_real;
    logic [DW-1:0] r_imag;
    logic          overflow;
    logic          div_zero;
  } cplx_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_ADD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  cplx_result_t expected_results[$];
  int unsigned  error_count = 0;
  int unsigned  sent_count = 0;
  int unsigned  result_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  ovf_seen = 0;
  int unsigned  dz_seen = 0;
  bit           allow_gaps = 1'b1;

  complex_arith_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Clamp a value to the signed data range; flag the clamp.
  function automatic logic [DW-1:0] saturate(input logic signed [127:0] v, inout logic ovf);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (DW - 1)) - 1;
    lo = -(128'sd1 <<< (DW - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Signed quotient num * 2^FB / den, truncated toward zero.
  function automatic logic signed [127:0] fixed_quotient(input logic signed [127:0] num,
                                                         input logic signed [127:0] den);
    logic signed [127:0] mag;
    mag = ((num < 0) ? -num : num) <<< FB;
    mag = mag / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
    logic signed [127:0] mag;
    mag = ((v < 0) ? -v : v) >>> FB;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic cplx_result_t complex_result(input cmd_e op,
      input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
      input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
    cplx_result_t res;
    logic signed [127:0] ar_w, ai_w, br_w, bi_w, den;
    logic ovf;
    ar_w = ar;
    ai_w = ai;
    br_w = br;
    bi_w = bi;
    ovf = 1'b0;
    res = '0;
    case (op)
      CMD_ADD: begin
        res.r_real = saturate(ar_w + br_w, ovf);
        res.r_imag = saturate(ai_w + bi_w, ovf);
      end
      CMD_SUB: begin
        res.r_real = saturate(ar_w - br_w, ovf);
        res.r_imag = saturate(ai_w - bi_w, ovf);
      end
      CMD_MUL: begin
        res.r_real = saturate(drop_frac(ar_w * br_w - ai_w * bi_w), ovf);
        res.r_imag = saturate(drop_frac(ar_w * bi_w + ai_w * br_w), ovf);
      end
      default: begin
        den = br_w * br_w + bi_w * bi_w;
        if (den == 0) begin
          res.div_zero = 1'b1;
        end else begin
          res.r_real = saturate(fixed_quotient(ar_w * br_w + ai_w * bi_w, den), ovf);
          res.r_imag = saturate(fixed_quotient(ai_w * br_w - ar_w * bi_w, den), ovf);
        end
      end
    endcase
    res.overflow = ovf;
    return res;
  endfunction

  // Send one operand pair and queue its expected result.
  task automatic send_operation(input cmd_e op, input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                                input logic [DW-1:0] br, input logic [DW-1:0] bi);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bi, br, ai, ar};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(complex_result(op, ar, ai, br, bi));
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [DW-1:0] random_operand();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return '0;
      3: return DW'($urandom_range(0, 1023)) - DW'(512);
      default: return DW'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic [DW-1:0] pmax, nmax, one;
    pmax = {1'b0, {(DW-1){1'b1}}};
    nmax = {1'b1, {(DW-1){1'b0}}};
    one  = DW'(1 << FB);
    send_operation(CMD_ADD, pmax, nmax, pmax, nmax);     // both parts clamp
    send_operation(CMD_ADD, pmax, pmax, nmax, nmax);
    send_operation(CMD_SUB, nmax, pmax, pmax, nmax);
    send_operation(CMD_SUB, one, '0, one, one);          // real minus complex
    send_operation(CMD_MUL, nmax, nmax, nmax, nmax);
    send_operation(CMD_MUL, pmax, nmax, nmax, pmax);
    send_operation(CMD_MUL, one, one, one, '0);          // complex times real
    send_operation(CMD_MUL, DW'(-3), '0, DW'(1), '0);    // truncation toward zero
    send_operation(CMD_DIV, one, one, '0, '0);           // divide by zero
    send_operation(CMD_DIV, pmax, nmax, '0, '0);
    send_operation(CMD_DIV, one, '0, one, one);          // real over complex
    send_operation(CMD_DIV, pmax, pmax, DW'(1), '0);     // quotient clamps
    send_operation(CMD_DIV, nmax, nmax, '0, DW'(1));
    send_operation(CMD_DIV, nmax, '0, nmax, nmax);
    send_operation(CMD_DIV, DW'(-5), DW'(7), DW'(3), DW'(-2));
    send_operation(CMD_ADD, '0, '0, '0, '0);
  endtask

  task automatic test_random(input int unsigned count);
    cmd_e op;
    logic [DW-1:0] bi;
    repeat (count) begin
      op = cmd_e'($urandom_range(0, 3));
      bi = ($urandom_range(0, 3) == 0) ? '0 : random_operand();
      if (op == CMD_DIV && $urandom_range(0, 15) == 0) begin
        send_operation(op, random_operand(), random_operand(), '0, '0);
      end else begin
        send_operation(op, random_operand(), random_operand(), random_operand(), bi);
      end
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    allow_gaps = 1'b0;
    test_random(count);
    s_axis_tvalid <= 1'b0;
  endtask

  // Receiver backpressure: bursts of stall, none once gaps are switched off.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (allow_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(1, 19);
        repeat (hold) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest queued expectation.
  always @(posedge clk_i) begin
    cplx_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        ovf_seen += want.overflow;
        dz_seen  += want.div_zero;
        if (m_axis_tdata[DW-1:0] !== want.r_real) begin
          $error("r_real: expected %h, actual %h", want.r_real, m_axis_tdata[DW-1:0]);
          error_count++;
        end
        if (m_axis_tdata[2*DW-1:DW] !== want.r_imag) begin
          $error("r_imag: expected %h, actual %h", want.r_imag, m_axis_tdata[2*DW-1:DW]);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.overflow) begin
          $error("overflow: expected %b, actual %b", want.overflow, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.div_zero) begin
          $error("div_zero: expected %b, actual %b", want.div_zero, m_axis_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[complex_arith_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned drain;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(430);
    test_back_to_back(120);
    drain = 0;
    while (expected_results.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("Sent %0d operations, checked %0d results (%0d saturated, %0d divide by zero).",
             sent_count, result_count, ovf_seen, dz_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[complex_arith_unit] OK");
    end else begin
      $display("[complex_arith_unit] ERROR");
    end
    $finish;
  end

endmodule
